FILE: rtl/aekq_pkg.sv
`default_nettype none
package aekq_pkg;

  // FIFO geometry
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Request modes
  localparam logic [1:0] MODE_INJECT = 2'd0;
  localparam logic [1:0] MODE_POLL   = 2'd1;
  localparam logic [1:0] MODE_PEEK   = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Key kinds
  localparam logic [2:0] KIND_PLAIN = 3'd0;
  localparam logic [2:0] KIND_UP    = 3'd1;
  localparam logic [2:0] KIND_DOWN  = 3'd2;
  localparam logic [2:0] KIND_RIGHT = 3'd3;
  localparam logic [2:0] KIND_LEFT  = 3'd4;
  localparam logic [2:0] KIND_PGUP  = 3'd5;
  localparam logic [2:0] KIND_PGDN  = 3'd6;

  // Terminal characters
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_A        = 8'h41;
  localparam logic [7:0] CH_B        = 8'h42;
  localparam logic [7:0] CH_C        = 8'h43;
  localparam logic [7:0] CH_D        = 8'h44;
  localparam logic [7:0] CH_0        = 8'h30;
  localparam logic [7:0] CH_9        = 8'h39;
  localparam logic [3:0] DIGIT_PGUP  = 4'd5;
  localparam logic [3:0] DIGIT_PGDN  = 4'd6;

  typedef enum logic [1:0] {
    PS_IDLE    = 2'd0,
    PS_ESC     = 2'd1,
    PS_BRACKET = 2'd2,
    PS_DIGIT   = 2'd3
  } parse_state_t;

  // Operations handed from the parser to the queue engine
  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_PUSH  = 3'd1,
    OP_POLL  = 3'd2,
    OP_PEEK  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] key;
  } event_t;

  typedef struct packed {
    op_t    op;
    event_t ev;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte_in;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       pushed;
    logic [2:0] key_kind;
    logic [7:0] key_byte;
    logic [4:0] fill_level;
  } rsp_t;

endpackage
`default_nettype wire

FILE: rtl/ansi_escape_key_event_queue_core.sv
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   aekq_pkg::req_t (mode, byte_in)
// rsp      out        rsp_valid/rsp_stall   aekq_pkg::rsp_t (status .. fill_level)
//
// One request per cycle sustained while rsp is not stalled. A request transfer
// writes its command into the two-slot command queue; the back end takes it
// from there and writes the result into the result register, which raises
// rsp_valid. The parser runs at request transfer time. rst (synchronous)
// empties queues and returns the parser to idle. A stalled rsp fills the
// command queue, after which req_stall rises.
`default_nettype none
module ansi_escape_key_event_queue_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire aekq_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output aekq_pkg::rsp_t      rsp
);

  aekq_pkg::cmd_t front_cmd;
  aekq_pkg::cmd_t head_cmd;
  logic           q_full;
  logic           q_head_valid;
  logic           q_pop;
  logic           take;

  assign req_stall = q_full;
  assign take      = req_valid && !q_full;

  aekq_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .req  (req),
    .cmd  (front_cmd)
  );

  aekq_cmd_queue u_cmd_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (head_cmd)
  );

  aekq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_head_valid),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

FILE: rtl/aekq_front.sv
`default_nettype none
module aekq_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire aekq_pkg::req_t req,
  output aekq_pkg::cmd_t     cmd
);

  aekq_pkg::parse_state_t state, state_next;
  logic [3:0]             held_digit, held_digit_next;

  logic is_digit;
  assign is_digit = (req.byte_in >= aekq_pkg::CH_0) && (req.byte_in <= aekq_pkg::CH_9);

  // Parser state; only moves on a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= aekq_pkg::PS_IDLE;
      held_digit <= 4'd0;
    end else if (take) begin
      state      <= state_next;
      held_digit <= held_digit_next;
    end
  end

  // Next state
  always_comb begin
    state_next      = state;
    held_digit_next = held_digit;
    if (req.mode == aekq_pkg::MODE_INJECT) begin
      unique case (state)
        aekq_pkg::PS_IDLE: begin
          state_next = (req.byte_in == aekq_pkg::CH_ESC) ? aekq_pkg::PS_ESC
                                                         : aekq_pkg::PS_IDLE;
        end
        aekq_pkg::PS_ESC: begin
          priority if (req.byte_in == aekq_pkg::CH_LBRACKET) state_next = aekq_pkg::PS_BRACKET;
          else if (req.byte_in == aekq_pkg::CH_ESC)          state_next = aekq_pkg::PS_ESC;
          else                                                state_next = aekq_pkg::PS_IDLE;
        end
        aekq_pkg::PS_BRACKET: begin
          if (is_digit) begin
            state_next      = aekq_pkg::PS_DIGIT;
            held_digit_next = req.byte_in[3:0];
          end else begin
            state_next = aekq_pkg::PS_IDLE;
          end
        end
        aekq_pkg::PS_DIGIT: begin
          state_next = aekq_pkg::PS_IDLE;
        end
        default: state_next = aekq_pkg::PS_IDLE;
      endcase
    end
  end

  // Command for the back end
  always_comb begin
    cmd.op      = aekq_pkg::OP_NOP;
    cmd.ev.kind = aekq_pkg::KIND_PLAIN;
    cmd.ev.key  = 8'd0;
    unique case (req.mode)
      aekq_pkg::MODE_INJECT: begin
        unique case (state)
          aekq_pkg::PS_IDLE: begin
            cmd.op     = aekq_pkg::OP_PUSH;
            cmd.ev.key = req.byte_in;
          end
          aekq_pkg::PS_ESC: begin
            if (req.byte_in != aekq_pkg::CH_LBRACKET) begin
              cmd.op     = aekq_pkg::OP_PUSH;
              cmd.ev.key = req.byte_in;
            end
          end
          aekq_pkg::PS_BRACKET: begin
            priority case (req.byte_in)
              aekq_pkg::CH_A: begin
                cmd.op = aekq_pkg::OP_PUSH; cmd.ev.kind = aekq_pkg::KIND_UP;
              end
              aekq_pkg::CH_B: begin
                cmd.op = aekq_pkg::OP_PUSH; cmd.ev.kind = aekq_pkg::KIND_DOWN;
              end
              aekq_pkg::CH_C: begin
                cmd.op = aekq_pkg::OP_PUSH; cmd.ev.kind = aekq_pkg::KIND_RIGHT;
              end
              aekq_pkg::CH_D: begin
                cmd.op = aekq_pkg::OP_PUSH; cmd.ev.kind = aekq_pkg::KIND_LEFT;
              end
              default: cmd.op = aekq_pkg::OP_NOP;
            endcase
          end
          aekq_pkg::PS_DIGIT: begin
            if (req.byte_in == aekq_pkg::CH_TILDE) begin
              if (held_digit == aekq_pkg::DIGIT_PGUP) begin
                cmd.op = aekq_pkg::OP_PUSH; cmd.ev.kind = aekq_pkg::KIND_PGUP;
              end else if (held_digit == aekq_pkg::DIGIT_PGDN) begin
                cmd.op = aekq_pkg::OP_PUSH; cmd.ev.kind = aekq_pkg::KIND_PGDN;
              end
            end
          end
          default: cmd.op = aekq_pkg::OP_NOP;
        endcase
      end
      aekq_pkg::MODE_POLL:  cmd.op = aekq_pkg::OP_POLL;
      aekq_pkg::MODE_PEEK:  cmd.op = aekq_pkg::OP_PEEK;
      aekq_pkg::MODE_CLEAR: cmd.op = aekq_pkg::OP_CLEAR;
      default:              cmd.op = aekq_pkg::OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/aekq_cmd_queue.sv
`default_nettype none
module aekq_cmd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire aekq_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output aekq_pkg::cmd_t      head_cmd
);

  // Two-slot queue between parser and queue engine
  aekq_pkg::cmd_t slot [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/aekq_back.sv
`default_nettype none
module aekq_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  input  wire aekq_pkg::cmd_t cmd,
  output logic                cmd_pop,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output aekq_pkg::rsp_t      rsp
);

  aekq_pkg::event_t                store [aekq_pkg::QUEUE_DEPTH];
  logic [aekq_pkg::PTR_W-1:0]      rd_ptr, rd_ptr_next;
  logic [aekq_pkg::PTR_W-1:0]      wr_ptr, wr_ptr_next;
  logic [aekq_pkg::CNT_W-1:0]      count, count_next;
  logic                            store_we;
  aekq_pkg::event_t                head;
  aekq_pkg::rsp_t                  result;
  logic                            fire;

  localparam logic [aekq_pkg::PTR_W-1:0] PTR_LAST = aekq_pkg::PTR_W'(aekq_pkg::QUEUE_DEPTH - 1);
  localparam logic [aekq_pkg::CNT_W-1:0] CNT_FULL = aekq_pkg::CNT_W'(aekq_pkg::QUEUE_DEPTH);

  // Work on a command whenever the result register is free or draining
  assign fire    = cmd_valid && (!rsp_valid || !rsp_stall);
  assign cmd_pop = fire;

  // Carry out one command
  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    count_next  = count;
    store_we    = 1'b0;
    result      = '0;
    unique case (cmd.op)
      aekq_pkg::OP_PUSH: begin
        if (count == CNT_FULL) begin
          result.status = aekq_pkg::STAT_FULL;
        end else begin
          store_we      = 1'b1;
          wr_ptr_next   = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
          count_next    = count + 1'b1;
          result.pushed = 1'b1;
        end
      end
      aekq_pkg::OP_POLL, aekq_pkg::OP_PEEK: begin
        if (count == '0) begin
          result.status = aekq_pkg::STAT_EMPTY;
        end else begin
          result.key_kind = head.kind;
          result.key_byte = (head.kind == aekq_pkg::KIND_PLAIN) ? head.key : 8'd0;
          if (cmd.op == aekq_pkg::OP_POLL) begin
            rd_ptr_next = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
            count_next  = count - 1'b1;
          end
        end
      end
      aekq_pkg::OP_CLEAR: begin
        rd_ptr_next = '0;
        wr_ptr_next = '0;
        count_next  = '0;
      end
      default: result.status = aekq_pkg::STAT_DONE;
    endcase
    result.fill_level = 5'(count_next);
  end

  // Event store
  always_ff @(posedge clk) begin
    if (fire && store_we) begin
      store[wr_ptr] <= cmd.ev;
    end
  end

  // Head entry, read ahead at the next read pointer; a push into an empty
  // store lands straight in the head
  always_ff @(posedge clk) begin
    if (fire) begin
      if (store_we && (wr_ptr == rd_ptr_next)) begin
        head <= cmd.ev;
      end else begin
        head <= store[rd_ptr_next];
      end
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else if (fire) begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= result;
    end
  end

endmodule
`default_nettype wire
